// ===== design/dyrc_pkg.sv =====
// Shared types and constants for the dyadic range cover block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package dyrc_pkg;

    localparam int IN_W    = 16;   // width of each range bound on the port
    localparam int WIDE_W  = 32;   // scratch width for zero extension
    localparam int PBITS_W = 5;    // width of the prefix length field
    localparam int TDATA_S = 32;   // slave tdata: two bounds
    localparam int TDATA_M = 24;   // master tdata: value and length, padded to bytes

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOW,
        ST_HIGH
    } dyrc_state_t;

    typedef enum logic {
        SEL_LOW,
        SEL_HIGH
    } emit_sel_t;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      step;
        logic      emit;
        emit_sel_t sel;
        logic      last;
        logic      empty;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic lo_gt_hi;
        logic lo_eq_hi;
        logic lo_odd;
        logic hi_odd;
        logic next_gt;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/dyrc_datapath.sv =====
// Datapath of the dyadic range cover: bound registers, halving step and result register.
// Depends on dyrc_pkg; driven by dyrc_ctrl through dp_cmd_t.
`default_nettype none

module dyrc_datapath #(
    parameter int KEY_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [dyrc_pkg::IN_W-1:0]    range_low,
    input  wire logic [dyrc_pkg::IN_W-1:0]    range_high,
    input  wire dyrc_pkg::dp_cmd_t            cmd,
    output dyrc_pkg::dp_stat_t                stat,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [dyrc_pkg::IN_W-1:0]         prefix_value,
    output logic [dyrc_pkg::PBITS_W-1:0]      prefix_bits,
    output logic                              is_last,
    output logic                              is_empty
);
    import dyrc_pkg::*;

    localparam int CW = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0]       bits_reg, bits_next;

    logic [WIDE_W-1:0]   low_wide, high_wide, val_wide, bits_wide;
    logic [KEY_BITS:0]   lo_inc;
    logic [KEY_BITS-1:0] lo_half, hi_dec, hi_half, sel_val;

    logic                val_reg, val_next;
    logic [IN_W-1:0]     value_reg, value_next;
    logic [PBITS_W-1:0]  pbits_reg, pbits_next;
    logic                last_reg, last_next;
    logic                empty_reg, empty_next;

    // bits of each bound above the key width are dropped
    assign low_wide  = WIDE_W'(range_low);
    assign high_wide = WIDE_W'(range_high);

    assign lo_inc  = {1'b0, lo_reg} + (KEY_BITS + 1)'(1);
    assign lo_half = lo_inc[KEY_BITS:1];
    assign hi_dec  = hi_reg - KEY_BITS'(1);
    assign hi_half = KEY_BITS'(hi_dec >> 1);

    always_comb begin
        stat.lo_gt_hi = lo_reg > hi_reg;
        stat.lo_eq_hi = lo_reg == hi_reg;
        stat.lo_odd   = lo_reg[0];
        stat.hi_odd   = hi_reg[0];
        stat.next_gt  = lo_half > hi_half;
        stat.out_free = !val_reg || out_ready;
    end

    always_comb begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        bits_next = bits_reg;
        if (cmd.load) begin
            lo_next   = low_wide[KEY_BITS-1:0];
            hi_next   = high_wide[KEY_BITS-1:0];
            bits_next = CW'(KEY_BITS);
        end else if (cmd.step) begin
            lo_next   = lo_half;
            hi_next   = hi_half;
            bits_next = bits_reg - CW'(1);
        end
    end

    assign sel_val   = (cmd.sel == SEL_HIGH) ? hi_reg : lo_reg;
    assign val_wide  = WIDE_W'(sel_val);
    assign bits_wide = WIDE_W'(bits_reg);

    always_comb begin
        val_next   = val_reg;
        value_next = value_reg;
        pbits_next = pbits_reg;
        last_next  = last_reg;
        empty_next = empty_reg;
        if (cmd.emit) begin
            val_next   = 1'b1;
            last_next  = cmd.last;
            empty_next = cmd.empty;
            if (cmd.empty) begin
                value_next = '0;
                pbits_next = '0;
            end else begin
                value_next = val_wide[IN_W-1:0];
                pbits_next = bits_wide[PBITS_W-1:0];
            end
        end else if (out_ready) begin
            val_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= 1'b0;
        end else begin
            val_reg <= val_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        bits_reg  <= bits_next;
        value_reg <= value_next;
        pbits_reg <= pbits_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
    end

    assign out_valid    = val_reg;
    assign prefix_value = value_reg;
    assign prefix_bits  = pbits_reg;
    assign is_last      = last_reg;
    assign is_empty     = empty_reg;

endmodule

`default_nettype wire

// ===== design/dyrc_ctrl.sv =====
// Sequencer of the dyadic range cover: walks the bit levels and issues load, step and emit.
// Depends on dyrc_pkg; reads dp_stat_t from dyrc_datapath.
`default_nettype none

module dyrc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire dyrc_pkg::dp_stat_t stat,
    output dyrc_pkg::dp_cmd_t       cmd
);
    import dyrc_pkg::*;

    dyrc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!stat.lo_gt_hi) begin
                    state_next = ST_LOW;
                end else if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOW: begin
                priority if (stat.lo_eq_hi) begin
                    if (stat.out_free) state_next = ST_IDLE;
                end else if (stat.lo_odd) begin
                    if (stat.out_free) state_next = ST_HIGH;
                end else if (!stat.hi_odd) begin
                    if (stat.out_free) state_next = stat.next_gt ? ST_IDLE : ST_LOW;
                end else begin
                    state_next = ST_LOW;
                end
            end
            ST_HIGH: begin
                if (stat.hi_odd || stat.out_free) begin
                    state_next = stat.next_gt ? ST_IDLE : ST_LOW;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        in_ready  = 1'b0;
        cmd       = '0;
        cmd.sel   = SEL_LOW;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHECK: begin
                if (stat.lo_gt_hi && stat.out_free) begin
                    cmd.emit  = 1'b1;
                    cmd.last  = 1'b1;
                    cmd.empty = 1'b1;
                end
            end
            ST_LOW: begin
                priority if (stat.lo_eq_hi) begin
                    cmd.emit = stat.out_free;
                    cmd.last = 1'b1;
                end else if (stat.lo_odd) begin
                    // last only if high adds nothing and the next level is empty
                    cmd.emit = stat.out_free;
                    cmd.last = stat.hi_odd && stat.next_gt;
                end else if (!stat.hi_odd) begin
                    cmd.emit = stat.out_free;
                    cmd.sel  = SEL_HIGH;
                    cmd.last = stat.next_gt;
                    cmd.step = stat.out_free;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_HIGH: begin
                if (!stat.hi_odd) begin
                    cmd.emit = stat.out_free;
                    cmd.sel  = SEL_HIGH;
                    cmd.last = stat.next_gt;
                    cmd.step = stat.out_free;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/dyadic_range_cover.sv =====
// Top level of the dyadic range cover: stream ports around the sequencer and the datapath.
// Depends on dyrc_pkg, dyrc_ctrl and dyrc_datapath.
`default_nettype none

// Takes one inclusive range per request and returns the minimal list of dyadic
// prefixes that tile it, low side before high side at each level, narrowest
// prefixes first; tlast marks the final prefix and tuser flags an empty range
// (low above high), which gives one all-zero result. Ranges are handled one at
// a time: a range is loaded, its order is checked, then the bit levels are
// walked from the narrowest up, through the high state as well where the low
// bound is odd, until the bounds meet or cross; an output stall holds the walk
// whenever a result is due. The sequencer steps one level per pass through the
// single halving adder pair and writes at most one result per cycle into the
// output register. A new range is taken once the last prefix of the previous
// one sits in the output register.
module dyadic_range_cover #(
    parameter int KEY_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [15:0] range_low, [31:16] range_high
    input  wire logic [dyrc_pkg::TDATA_S-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] prefix_value, [20:16] prefix_bits, [23:21] zero
    output logic [dyrc_pkg::TDATA_M-1:0]       m_tdata,
    output logic                               m_tlast,
    // [0] is_empty
    output logic                               m_tuser
);
    import dyrc_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [IN_W-1:0]     prefix_value;
    logic [PBITS_W-1:0]  prefix_bits;

    dyrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dyrc_datapath #(
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .range_low    (s_tdata[IN_W-1:0]),
        .range_high   (s_tdata[2*IN_W-1:IN_W]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .prefix_value (prefix_value),
        .prefix_bits  (prefix_bits),
        .is_last      (m_tlast),
        .is_empty     (m_tuser)
    );

    assign m_tdata = {(TDATA_M - IN_W - PBITS_W)'(0), prefix_bits, prefix_value};

    // an empty range yields exactly one all-zero result
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("empty result not final or not zero");

    // a prefix never keeps more bits than the key has
    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({(WIDE_W - PBITS_W)'(0), m_tdata[IN_W+PBITS_W-1:IN_W]}
                      <= WIDE_W'(KEY_BITS)))
        else $error("prefix length above key width");

    // one range at a time: the port closes right after a request
    a_one_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second range taken while busy");

endmodule

`default_nettype wire

// ===== test/dyadic_range_cover_checker.sv =====
`timescale 1ns / 1ps
// Checker for the dyadic range cover: watches both stream channels, predicts the
// prefix list of each accepted range and compares it with what the block returns.
// Depends on dyrc_pkg for the port widths.

module dyadic_range_cover_checker #(
    parameter int KEY_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // [15:0] range_low, [31:16] range_high
    input  logic [dyrc_pkg::TDATA_S-1:0]  s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] prefix_value, [20:16] prefix_bits, [23:21] zero
    input  logic [dyrc_pkg::TDATA_M-1:0]  m_tdata,
    input  logic                          m_tlast,
    // [0] is_empty
    input  logic                          m_tuser,
    output int                            error_count,
    output int                            pending
);

    typedef struct packed {
        logic [15:0] value;
        logic [4:0]  nbits;
        logic        last;
        logic        empty;
    } prefix_t;

    prefix_t prefix_q[$];

    initial begin
        error_count = 0;
        pending     = 0;
    end

    // Append the minimal dyadic cover of [range_lo, range_hi] to the prefix queue.
    function automatic void predict_cover(input logic [15:0] range_lo,
                                          input logic [15:0] range_hi);
        logic [63:0] key_mask;
        logic [63:0] lo;
        logic [63:0] hi;
        int          nbits;
        int          count;
        prefix_t     found[$];
        prefix_t     item;

        key_mask = (64'd1 << KEY_BITS) - 64'd1;
        lo       = 64'(range_lo) & key_mask;
        hi       = 64'(range_hi) & key_mask;
        nbits    = KEY_BITS;
        count    = 0;

        if (lo > hi) begin
            item     = '{value: 16'd0, nbits: 5'd0, last: 1'b1, empty: 1'b1};
            prefix_q = {prefix_q, item};
            return;
        end

        // low side goes out before high side at each level
        while (lo < hi && count < 2 * KEY_BITS - 1) begin
            if (lo[0]) begin
                item  = '{value: lo[15:0], nbits: nbits[4:0], last: 1'b0, empty: 1'b0};
                found = {found, item};
                count++;
            end
            if (!hi[0]) begin
                item  = '{value: hi[15:0], nbits: nbits[4:0], last: 1'b0, empty: 1'b0};
                found = {found, item};
                count++;
            end
            lo = (lo + 64'd1) >> 1;
            hi = (hi - 64'd1) >> 1;
            nbits--;
        end

        if (lo == hi && count < 2 * KEY_BITS) begin
            item  = '{value: lo[15:0], nbits: nbits[4:0], last: 1'b0, empty: 1'b0};
            found = {found, item};
            count++;
        end

        if (count == 0) begin
            item     = '{value: 16'd0, nbits: 5'd0, last: 1'b1, empty: 1'b1};
            prefix_q = {prefix_q, item};
            return;
        end

        for (int i = 0; i < found.size(); i++) begin
            item      = found[i];
            item.last = (i == found.size() - 1);
            prefix_q  = {prefix_q, item};
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        prefix_t want;

        if (!aresetn) begin
            prefix_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (prefix_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value %0h bits %0d",
                             $time, m_tdata[15:0], m_tdata[20:16]);
                    error_count++;
                end else begin
                    want = prefix_q.pop_front();
                    check_field("prefix_value", 32'(want.value), 32'(m_tdata[15:0]));
                    check_field("prefix_bits", 32'(want.nbits), 32'(m_tdata[20:16]));
                    check_field("tdata padding", 32'd0, 32'(m_tdata[23:21]));
                    check_field("tlast", 32'(want.last), 32'(m_tlast));
                    check_field("tuser", 32'(want.empty), 32'(m_tuser));
                end
            end
            if (s_tvalid && s_tready)
                predict_cover(s_tdata[15:0], s_tdata[31:16]);
        end
        pending <= prefix_q.size();
    end

endmodule

// ===== test/dyadic_range_cover_tb.sv =====
`timescale 1ns / 1ps
// Top of the dyadic range cover testbench: clock, reset, request stimulus and the verdict.
// Depends on dyrc_pkg, dyadic_range_cover and dyadic_range_cover_checker.

module dyadic_range_cover_tb;

    localparam int KEY_BITS     = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 35;
    localparam int TIMEOUT_NS   = 5_000_000;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // [15:0] range_low, [31:16] range_high
    logic [dyrc_pkg::TDATA_S-1:0]  s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // [15:0] prefix_value, [20:16] prefix_bits, [23:21] zero
    logic [dyrc_pkg::TDATA_M-1:0]  m_tdata;
    logic                          m_tlast;
    // [0] is_empty
    logic                          m_tuser;

    int error_count;
    int pending;
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    dyadic_range_cover #(
        .KEY_BITS (KEY_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    dyadic_range_cover_checker #(
        .KEY_BITS (KEY_BITS)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .error_count (error_count),
        .pending     (pending)
    );

    // Receiver: random stalls, or a long hold-off whenever the stimulus asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Offer one request and hold it until the block takes it.
    task automatic send_range(input logic [15:0] range_lo, input logic [15:0] range_hi);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {range_hi, range_lo};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Mostly well-formed ranges of mixed spans, plus aligned blocks, points and empties.
    task automatic send_random_range();
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] mask;
        logic [16:0] top;
        int          kind;

        kind = $urandom_range(9);
        lo   = 16'($urandom);
        hi   = 16'($urandom);
        mask = 16'((32'd1 << $urandom_range(16)) - 1);
        case (kind)
            0, 1, 2, 3: begin
                top = 17'(lo) + 17'(16'($urandom) & mask);
                hi  = top[16] ? 16'hFFFF : top[15:0];
            end
            4, 5: ;
            6: begin
                lo = lo & ~mask;
                hi = lo | mask;
                if ($urandom_range(1) != 0)
                    hi = hi - 16'($urandom_range(1));
                else if (lo != 16'hFFFF)
                    lo = lo + 16'($urandom_range(1));
            end
            7: hi = lo;
            8: begin
                if (lo == hi)
                    hi = lo ^ 16'h0001;
                if (lo < hi) begin
                    lo = lo ^ hi;
                    hi = lo ^ hi;
                    lo = lo ^ hi;
                end
            end
            default: begin
                if ($urandom_range(1) != 0)
                    lo = 16'h0000;
                else
                    hi = 16'hFFFF;
            end
        endcase
        send_range(lo, hi);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        repeat (n_items)
            send_random_range();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full key space, single points, widest cover, empties, aligned halves
        send_range(16'h0000, 16'hFFFF);
        send_range(16'h0000, 16'h0000);
        send_range(16'hFFFF, 16'hFFFF);
        send_range(16'h0005, 16'h0005);
        send_range(16'h0001, 16'hFFFE);
        send_range(16'h0001, 16'h0000);
        send_range(16'hFFFF, 16'h0000);
        send_range(16'h0064, 16'h0063);
        send_range(16'h0000, 16'h0001);
        send_range(16'h0001, 16'h0002);
        send_range(16'h0002, 16'h0003);
        send_range(16'h0003, 16'h0004);
        send_range(16'h8000, 16'hFFFF);
        send_range(16'h0000, 16'h7FFF);
        send_range(16'h1234, 16'h5678);
        send_range(16'hFFFE, 16'hFFFF);
        send_range(16'h0001, 16'hFFFF);
        send_range(16'h0000, 16'hFFFE);
        send_range(16'h7FFF, 16'h8000);
        send_range(16'hAAAA, 16'h5555);

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(73, 0, PHASE_ITEMS);
        run_phase(0, 73, PHASE_ITEMS);
        run_phase(15, 15, PHASE_ITEMS);

        // long receiver hold-off while requests keep coming back to back
        hold_req <= hold_req + 1;
        run_phase(0, 0, 10);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== dyadic_range_cover.f =====
design/dyrc_pkg.sv
design/dyrc_datapath.sv
design/dyrc_ctrl.sv
design/dyadic_range_cover.sv
test/dyadic_range_cover_checker.sv
test/dyadic_range_cover_tb.sv
